// ----- rtl/obc_pkg.sv -----
// Shared constants, types and the CORDIC arctangent table for the box collision block.
package obc_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int ANGLE_BITS_DEF = 16;

	localparam int CORDIC_STEPS = 16;
	localparam int TRIG_W       = 18;
	localparam int XY_W         = 33;
	localparam int Z_W          = 34;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// arctangent of 2^-i on a 2^32-per-turn scale
	function automatic logic signed [Z_W-1:0] atan_turn(input int i);
		logic signed [Z_W-1:0] v;
		case (i)
			0:       v = 34'sd536870912;
			1:       v = 34'sd316933406;
			2:       v = 34'sd167458907;
			3:       v = 34'sd85004756;
			4:       v = 34'sd42667331;
			5:       v = 34'sd21354465;
			6:       v = 34'sd10680862;
			7:       v = 34'sd5340757;
			8:       v = 34'sd2670675;
			9:       v = 34'sd1335087;
			10:      v = 34'sd667544;
			11:      v = 34'sd333772;
			12:      v = 34'sd166886;
			13:      v = 34'sd83443;
			14:      v = 34'sd41722;
			default: v = 34'sd20861;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/oriented_box_collision.sv -----
// Top level: separating-axis overlap test of two rotated boxes with first box bound.
//
//  channel   direction  transfer when          payload
//  command   in         start && !busy         a_*, b_* center, size, angle
//  result    out        done (one cycle)       overlap, bbox_min_*, bbox_span_*
//
// One pair is taken every cycle while busy is low; from transfer to done it passes
// the 16-step CORDIC pipeline, corner stages, queue and projection stages.
// arst_n clears all valid bits; no clearing pass is needed.
// The result side cannot stall; the queue drains each cycle, so busy stays low
// in steady streaming.
module oriented_box_collision #(
	parameter int COORD_BITS = obc_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = obc_pkg::ANGLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic [COORD_BITS-2:0]        a_width,
	input  logic [COORD_BITS-2:0]        a_height,
	input  logic [ANGLE_BITS-1:0]        a_angle,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic [COORD_BITS-2:0]        b_width,
	input  logic [COORD_BITS-2:0]        b_height,
	input  logic [ANGLE_BITS-1:0]        b_angle,
	output logic                         done,
	output logic                         overlap,
	output logic signed [COORD_BITS-1:0] bbox_min_x,
	output logic signed [COORD_BITS-1:0] bbox_min_y,
	output logic [COORD_BITS-2:0]        bbox_span_x,
	output logic [COORD_BITS-2:0]        bbox_span_y
);

	localparam int CW = COORD_BITS + 3;
	localparam int QW = 16 * CW + 4 * obc_pkg::TRIG_W;

	logic             push, rd_valid;
	logic [QW-1:0]    push_data, rd_data;
	obc_pkg::q_stat_t stat;

	assign busy = stat.full;

	obc_front #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.a_center_x(a_center_x),
		.a_center_y(a_center_y),
		.a_width   (a_width),
		.a_height  (a_height),
		.a_angle   (a_angle),
		.b_center_x(b_center_x),
		.b_center_y(b_center_y),
		.b_width   (b_width),
		.b_height  (b_height),
		.b_angle   (b_angle),
		.push      (push),
		.push_data (push_data)
	);

	obc_queue #(.WIDTH(QW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.stat     (stat)
	);

	obc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rd_valid),
		.in_data    (rd_data),
		.done       (done),
		.overlap    (overlap),
		.bbox_min_x (bbox_min_x),
		.bbox_min_y (bbox_min_y),
		.bbox_span_x(bbox_span_x),
		.bbox_span_y(bbox_span_y)
	);

endmodule

// ----- rtl/obc_cordic.sv -----
// Pipelined CORDIC: cosine and sine of a turn-fraction angle, one stage per iteration.
module obc_cordic #(
	parameter int ANGLE_BITS = obc_pkg::ANGLE_BITS_DEF,
	parameter int PASS_W     = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [ANGLE_BITS-1:0]             angle,
	input  logic [PASS_W-1:0]                 pass_in,
	output logic                              out_valid,
	output logic signed [obc_pkg::TRIG_W-1:0] cs,
	output logic signed [obc_pkg::TRIG_W-1:0] sn,
	output logic [PASS_W-1:0]                 pass_out
);

	localparam int N  = obc_pkg::CORDIC_STEPS;
	localparam int XW = obc_pkg::XY_W;
	localparam int ZW = obc_pkg::Z_W;
	localparam int TW = obc_pkg::TRIG_W;

	logic signed [XW-1:0] x_s [N+1];
	logic signed [XW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic [1:0]           q_s [N+1];
	logic [PASS_W-1:0]    p_s [N+1];
	logic                 v_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= obc_pkg::CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= ZW'(angle[ANGLE_BITS-3:0]) <<< (32 - ANGLE_BITS);
		q_s[0] <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
		p_s[0] <= pass_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - obc_pkg::atan_turn(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + obc_pkg::atan_turn(i);
			end
			q_s[i+1] <= q_s[i];
			p_s[i+1] <= p_s[i];
		end
	end

	logic signed [XW-1:0] c_full, s_full;
	logic signed [TW-1:0] c_r, s_r, cs_d, sn_d;

	always_comb begin
		c_full = (x_s[N] + XW'(1 <<< 13)) >>> 14;
		s_full = (y_s[N] + XW'(1 <<< 13)) >>> 14;
		c_r    = c_full[TW-1:0];
		s_r    = s_full[TW-1:0];
		// exact quarter-turn rotation by quadrant
		case (obc_pkg::quad_t'(q_s[N]))
			obc_pkg::QUAD_0: begin cs_d = c_r;  sn_d = s_r;  end
			obc_pkg::QUAD_1: begin cs_d = -s_r; sn_d = c_r;  end
			obc_pkg::QUAD_2: begin cs_d = -c_r; sn_d = -s_r; end
			default:         begin cs_d = s_r;  sn_d = -c_r; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		cs       <= cs_d;
		sn       <= sn_d;
		pass_out <= p_s[N];
	end

endmodule

// ----- rtl/obc_front.sv -----
// Front end: trig of both angles, half-edge vectors and the eight corners.
module obc_front #(
	parameter int COORD_BITS = obc_pkg::COORD_BITS_DEF,
	parameter int ANGLE_BITS = obc_pkg::ANGLE_BITS_DEF,
	localparam int CW = COORD_BITS + 3,
	localparam int QW = 16 * CW + 4 * obc_pkg::TRIG_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] a_center_x,
	input  logic signed [COORD_BITS-1:0] a_center_y,
	input  logic [COORD_BITS-2:0]        a_width,
	input  logic [COORD_BITS-2:0]        a_height,
	input  logic [ANGLE_BITS-1:0]        a_angle,
	input  logic signed [COORD_BITS-1:0] b_center_x,
	input  logic signed [COORD_BITS-1:0] b_center_y,
	input  logic [COORD_BITS-2:0]        b_width,
	input  logic [COORD_BITS-2:0]        b_height,
	input  logic [ANGLE_BITS-1:0]        b_angle,
	output logic                         push,
	output logic [QW-1:0]                push_data
);

	localparam int TW = obc_pkg::TRIG_W;
	localparam int C  = COORD_BITS;
	localparam int PW = 4 * C - 2;
	localparam int HW = TW + C;

	logic [ANGLE_BITS-1:0]  ang   [2];
	logic [PW-1:0]          pin   [2];
	logic [PW-1:0]          pout  [2];
	logic                   tv    [2];
	logic signed [TW-1:0]   tcs   [2];
	logic signed [TW-1:0]   tsn   [2];

	assign ang[0] = a_angle;
	assign ang[1] = b_angle;
	assign pin[0] = {a_center_x, a_center_y, a_width, a_height};
	assign pin[1] = {b_center_x, b_center_y, b_width, b_height};

	for (genvar b = 0; b < 2; b++) begin : g_trig
		obc_cordic #(.ANGLE_BITS(ANGLE_BITS), .PASS_W(PW)) u_cordic (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (in_valid),
			.angle    (ang[b]),
			.pass_in  (pin[b]),
			.out_valid(tv[b]),
			.cs       (tcs[b]),
			.sn       (tsn[b]),
			.pass_out (pout[b])
		);
	end

	logic                 v_s1, v_s2;
	logic signed [HW-1:0] uxp_s1 [2], uyp_s1 [2], vxp_s1 [2], vyp_s1 [2];
	logic signed [C-1:0]  cx_s1 [2], cy_s1 [2];
	logic signed [TW-1:0] cs_s1 [2], sn_s1 [2], cs_s2 [2], sn_s2 [2];
	logic signed [CW-1:0] px_s2 [2][4], py_s2 [2][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= tv[0] && tv[1];
			v_s2 <= v_s1;
		end
	end

	for (genvar b = 0; b < 2; b++) begin : g_box
		logic signed [C-1:0]  wv, hv;
		logic signed [HW-1:0] ux_f, uy_f, vx_f, vy_f;
		logic signed [CW-1:0] ux, uy, vx, vy, cxe, cye;

		assign wv = $signed({1'b0, pout[b][2*C-3:C-1]});
		assign hv = $signed({1'b0, pout[b][C-2:0]});

		always_ff @(posedge clk) begin
			uxp_s1[b] <= tcs[b] * wv;
			uyp_s1[b] <= tsn[b] * wv;
			vxp_s1[b] <= -(tsn[b] * hv);
			vyp_s1[b] <= tcs[b] * hv;
			cx_s1[b]  <= pout[b][PW-1:PW-C];
			cy_s1[b]  <= pout[b][PW-C-1:PW-2*C];
			cs_s1[b]  <= tcs[b];
			sn_s1[b]  <= tsn[b];
		end

		// round to coordinate units, halving on the way
		always_comb begin
			ux_f = (uxp_s1[b] + HW'(1 <<< 16)) >>> 17;
			uy_f = (uyp_s1[b] + HW'(1 <<< 16)) >>> 17;
			vx_f = (vxp_s1[b] + HW'(1 <<< 16)) >>> 17;
			vy_f = (vyp_s1[b] + HW'(1 <<< 16)) >>> 17;
			ux   = ux_f[CW-1:0];
			uy   = uy_f[CW-1:0];
			vx   = vx_f[CW-1:0];
			vy   = vy_f[CW-1:0];
			cxe  = CW'(cx_s1[b]);
			cye  = CW'(cy_s1[b]);
		end

		always_ff @(posedge clk) begin
			px_s2[b][0] <= cxe - ux - vx;
			py_s2[b][0] <= cye - uy - vy;
			px_s2[b][1] <= cxe + ux - vx;
			py_s2[b][1] <= cye + uy - vy;
			px_s2[b][2] <= cxe + ux + vx;
			py_s2[b][2] <= cye + uy + vy;
			px_s2[b][3] <= cxe - ux + vx;
			py_s2[b][3] <= cye - uy + vy;
			cs_s2[b]    <= cs_s1[b];
			sn_s2[b]    <= sn_s1[b];
		end

		for (genvar c = 0; c < 4; c++) begin : g_pack
			assign push_data[(b*8+c)*CW +: CW]   = px_s2[b][c];
			assign push_data[(b*8+4+c)*CW +: CW] = py_s2[b][c];
		end
		assign push_data[16*CW + (2*b)*TW +: TW]   = cs_s2[b];
		assign push_data[16*CW + (2*b+1)*TW +: TW] = sn_s2[b];
	end

	assign push = v_s2;

endmodule

// ----- rtl/obc_queue.sv -----
// Short queue between front and back end, with registered read data.
module obc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	output obc_pkg::q_stat_t stat
);

	localparam int QD = obc_pkg::QUEUE_DEPTH;
	localparam int AW = $clog2(QD);
	localparam int NW = $clog2(QD + 1);

	logic [WIDTH-1:0] mem_q [QD];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    cnt_q;
	logic             pop;

	// back end never stalls: drain whenever something is held
	assign pop        = !stat.empty;
	assign stat.full  = (cnt_q == NW'(QD));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			rd_data <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			rd_valid <= 1'b0;
		end else begin
			rd_valid <= pop;
			if (push) begin
				wr_ptr_q <= AW'((32'(wr_ptr_q) + 1) % QD);
			end
			if (pop) begin
				rd_ptr_q <= AW'((32'(rd_ptr_q) + 1) % QD);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(QD)) else $error("queue count beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop)) else $error("transfer into full queue");
	a_rd_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid |-> $past(cnt_q != '0)) else $error("read from empty queue");

endmodule

// ----- rtl/obc_back.sv -----
// Back end: projections onto four axes, separation test and first box bound.
module obc_back #(
	parameter int COORD_BITS = obc_pkg::COORD_BITS_DEF,
	localparam int CW = COORD_BITS + 3,
	localparam int QW = 16 * CW + 4 * obc_pkg::TRIG_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [QW-1:0]                in_data,
	output logic                         done,
	output logic                         overlap,
	output logic signed [COORD_BITS-1:0] bbox_min_x,
	output logic signed [COORD_BITS-1:0] bbox_min_y,
	output logic [COORD_BITS-2:0]        bbox_span_x,
	output logic [COORD_BITS-2:0]        bbox_span_y
);

	localparam int TW = obc_pkg::TRIG_W;
	localparam int PW = CW + TW;
	localparam int DW = PW + 1;
	localparam logic signed [CW-1:0] CMAX = CW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] CMIN = -CMAX - CW'(1);

	logic signed [CW-1:0] px [2][4], py [2][4];
	logic signed [TW-1:0] tr [4];
	logic signed [TW-1:0] ax [4], ay [4];

	for (genvar b = 0; b < 2; b++) begin : g_unpack
		for (genvar c = 0; c < 4; c++) begin : g_c
			assign px[b][c] = in_data[(b*8+c)*CW +: CW];
			assign py[b][c] = in_data[(b*8+4+c)*CW +: CW];
		end
	end
	for (genvar t = 0; t < 4; t++) begin : g_tr
		assign tr[t] = in_data[16*CW + t*TW +: TW];
	end

	// edge axes of both boxes
	always_comb begin
		ax[0] = tr[0];  ay[0] = tr[1];
		ax[1] = -tr[1]; ay[1] = tr[0];
		ax[2] = tr[2];  ay[2] = tr[3];
		ax[3] = -tr[3]; ay[3] = tr[2];
	end

	logic                 v_s2, v_s3, v_s4;
	logic signed [PW-1:0] prx_s2 [4][2][4], pry_s2 [4][2][4];
	logic signed [DW-1:0] d_s3 [4][2][4];
	logic signed [DW-1:0] lo_s4 [4][2], hi_s4 [4][2];
	logic signed [CW-1:0] mnx_s2, mny_s2, mxx_s2, mxy_s2;
	logic signed [CW-1:0] mnx_s3, mny_s3, mxx_s3, mxy_s3;
	logic signed [CW-1:0] mnx_s4, mny_s4, mxx_s4, mxy_s4;
	logic signed [CW-1:0] mnx_d, mny_d, mxx_d, mxy_d;
	logic signed [DW-1:0] lo_d [4][2], hi_d [4][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	always_comb begin
		mnx_d = px[0][0]; mxx_d = px[0][0];
		mny_d = py[0][0]; mxy_d = py[0][0];
		for (int c = 1; c < 4; c++) begin
			if (px[0][c] < mnx_d) mnx_d = px[0][c];
			if (px[0][c] > mxx_d) mxx_d = px[0][c];
			if (py[0][c] < mny_d) mny_d = py[0][c];
			if (py[0][c] > mxy_d) mxy_d = py[0][c];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int b = 0; b < 2; b++) begin
				for (int c = 0; c < 4; c++) begin
					prx_s2[i][b][c] <= px[b][c] * ax[i];
					pry_s2[i][b][c] <= py[b][c] * ay[i];
					d_s3[i][b][c]   <= DW'(prx_s2[i][b][c]) + DW'(pry_s2[i][b][c]);
				end
			end
		end
		mnx_s2 <= mnx_d; mny_s2 <= mny_d; mxx_s2 <= mxx_d; mxy_s2 <= mxy_d;
		mnx_s3 <= mnx_s2; mny_s3 <= mny_s2; mxx_s3 <= mxx_s2; mxy_s3 <= mxy_s2;
		mnx_s4 <= mnx_s3; mny_s4 <= mny_s3; mxx_s4 <= mxx_s3; mxy_s4 <= mxy_s3;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int b = 0; b < 2; b++) begin
				lo_d[i][b] = d_s3[i][b][0];
				hi_d[i][b] = d_s3[i][b][0];
				for (int c = 1; c < 4; c++) begin
					if (d_s3[i][b][c] < lo_d[i][b]) lo_d[i][b] = d_s3[i][b][c];
					if (d_s3[i][b][c] > hi_d[i][b]) hi_d[i][b] = d_s3[i][b][c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_s4 <= lo_d;
		hi_s4 <= hi_d;
	end

	logic                 sep;
	logic signed [CW:0]   spx, spy;
	logic signed [CW-1:0] cmnx, cmny;

	always_comb begin
		sep = 1'b0;
		for (int i = 0; i < 4; i++) begin
			// touching counts as separate
			if (hi_s4[i][0] <= lo_s4[i][1] || hi_s4[i][1] <= lo_s4[i][0]) sep = 1'b1;
		end
		spx  = (CW+1)'(mxx_s4) - (CW+1)'(mnx_s4);
		spy  = (CW+1)'(mxy_s4) - (CW+1)'(mny_s4);
		cmnx = (mnx_s4 < CMIN) ? CMIN : ((mnx_s4 > CMAX) ? CMAX : mnx_s4);
		cmny = (mny_s4 < CMIN) ? CMIN : ((mny_s4 > CMAX) ? CMAX : mny_s4);
	end

	always_ff @(posedge clk) begin
		overlap     <= !sep;
		bbox_min_x  <= cmnx[COORD_BITS-1:0];
		bbox_min_y  <= cmny[COORD_BITS-1:0];
		bbox_span_x <= (spx > (CW+1)'(CMAX)) ? CMAX[COORD_BITS-2:0] : spx[COORD_BITS-2:0];
		bbox_span_y <= (spy > (CW+1)'(CMAX)) ? CMAX[COORD_BITS-2:0] : spy[COORD_BITS-2:0];
	end

endmodule

// ----- tb/tb_oriented_box_collision.sv -----
// Self-checking testbench for the oriented box collision block.
module tb_oriented_box_collision;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = obc_pkg::COORD_BITS_DEF;
	localparam int AB = obc_pkg::ANGLE_BITS_DEF;
	localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam int TAIL_CYCLES = 60;

	typedef struct {
		logic signed [CB-1:0] acx, acy, bcx, bcy;
		logic [CB-2:0]        aw, ah, bw, bh;
		logic [AB-1:0]        aa, ba;
		int                   idle_pct;
		bit                   drain;
	} box_pair_t;

	typedef struct {
		logic                 ovl;
		logic signed [CB-1:0] mnx, mny;
		logic [CB-2:0]        spx, spy;
	} box_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CB-1:0] a_center_x = '0, a_center_y = '0, b_center_x = '0, b_center_y = '0;
	logic [CB-2:0] a_width = '0, a_height = '0, b_width = '0, b_height = '0;
	logic [AB-1:0] a_angle = '0, b_angle = '0;
	logic done, overlap;
	logic signed [CB-1:0] bbox_min_x, bbox_min_y;
	logic [CB-2:0] bbox_span_x, bbox_span_y;

	box_pair_t   pending_pairs[$];
	box_result_t expected_results[$];
	box_pair_t   cur_pair;
	int          errors = 0;

	oriented_box_collision i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_center_x(a_center_x), .a_center_y(a_center_y),
		.a_width(a_width), .a_height(a_height), .a_angle(a_angle),
		.b_center_x(b_center_x), .b_center_y(b_center_y),
		.b_width(b_width), .b_height(b_height), .b_angle(b_angle),
		.done(done), .overlap(overlap),
		.bbox_min_x(bbox_min_x), .bbox_min_y(bbox_min_y),
		.bbox_span_x(bbox_span_x), .bbox_span_y(bbox_span_y)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// cosine and sine in 16 fraction bits
	function automatic void angle_trig(input logic [AB-1:0] ang, output longint cs,
			output longint sn);
		obc_pkg::quad_t q;
		longint x, y, z, dx, dy, c, s;
		q = obc_pkg::quad_t'(ang[AB-1 -: 2]);
		z = longint'(ang[AB-3:0]) << (32 - AB);
		x = longint'(obc_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < obc_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(obc_pkg::atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(obc_pkg::atan_turn(i));
			end
		end
		c = (x + (longint'(1) << 13)) >>> 14;
		s = (y + (longint'(1) << 13)) >>> 14;
		case (q)
			obc_pkg::QUAD_0: begin cs = c;  sn = s;  end
			obc_pkg::QUAD_1: begin cs = -s; sn = c;  end
			obc_pkg::QUAD_2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic longint halve_round(longint p);
		return (p + (longint'(1) << 16)) >>> 17;
	endfunction

	function automatic void box_corners(input longint cx, cy, w, h, cs, sn,
			output longint px[4], output longint py[4]);
		longint ux, uy, vx, vy;
		ux = halve_round(cs * w);
		uy = halve_round(sn * w);
		vx = halve_round(-sn * h);
		vy = halve_round(cs * h);
		px[0] = cx - ux - vx; py[0] = cy - uy - vy;
		px[1] = cx + ux - vx; py[1] = cy + uy - vy;
		px[2] = cx + ux + vx; py[2] = cy + uy + vy;
		px[3] = cx - ux + vx; py[3] = cy - uy + vy;
	endfunction

	function automatic void project_span(input longint px[4], input longint py[4],
			input longint ax, ay, output longint lo, output longint hi);
		longint d;
		lo = px[0] * ax + py[0] * ay;
		hi = lo;
		for (int i = 1; i < 4; i++) begin
			d = px[i] * ax + py[i] * ay;
			if (d < lo) lo = d;
			if (d > hi) hi = d;
		end
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic box_result_t collide(box_pair_t p);
		box_result_t r;
		longint ac, as_, bc, bs, alo, ahi, blo, bhi, mnx, mxx, mny, mxy;
		longint pax[4], pay[4], pbx[4], pby[4], axx[4], axy[4];
		bit sep;
		angle_trig(p.aa, ac, as_);
		angle_trig(p.ba, bc, bs);
		box_corners(longint'(p.acx), longint'(p.acy), longint'(p.aw), longint'(p.ah),
			ac, as_, pax, pay);
		box_corners(longint'(p.bcx), longint'(p.bcy), longint'(p.bw), longint'(p.bh),
			bc, bs, pbx, pby);
		axx[0] = ac;   axy[0] = as_;
		axx[1] = -as_; axy[1] = ac;
		axx[2] = bc;   axy[2] = bs;
		axx[3] = -bs;  axy[3] = bc;
		sep = 0;
		for (int i = 0; i < 4; i++) begin
			project_span(pax, pay, axx[i], axy[i], alo, ahi);
			project_span(pbx, pby, axx[i], axy[i], blo, bhi);
			// touching counts as separate
			if (ahi <= blo || bhi <= alo) sep = 1;
		end
		mnx = pax[0]; mxx = pax[0]; mny = pay[0]; mxy = pay[0];
		for (int i = 1; i < 4; i++) begin
			if (pax[i] < mnx) mnx = pax[i];
			if (pax[i] > mxx) mxx = pax[i];
			if (pay[i] < mny) mny = pay[i];
			if (pay[i] > mxy) mxy = pay[i];
		end
		r.ovl = !sep;
		r.mnx = CB'(clip(mnx, CMIN, CMAX));
		r.mny = CB'(clip(mny, CMIN, CMAX));
		r.spx = (CB-1)'(clip(mxx - mnx, 0, CMAX));
		r.spy = (CB-1)'(clip(mxy - mny, 0, CMAX));
		return r;
	endfunction

	// driver: one transfer per edge at most, start changes once per step
	always @(posedge clk) begin
		logic      next_start;
		box_pair_t nx;
		if (arst_n) begin
			next_start = start;
			if (start && !busy) begin
				expected_results.push_back(collide(cur_pair));
				next_start = 1'b0;
			end
			if (!next_start && pending_pairs.size() > 0) begin
				nx = pending_pairs[0];
				if (nx.drain && (expected_results.size() > 0 || start)) begin
					next_start = 1'b0;
				end else if ($urandom_range(99) >= nx.idle_pct) begin
					void'(pending_pairs.pop_front());
					cur_pair <= nx;
					a_center_x <= nx.acx; a_center_y <= nx.acy;
					a_width <= nx.aw; a_height <= nx.ah; a_angle <= nx.aa;
					b_center_x <= nx.bcx; b_center_y <= nx.bcy;
					b_width <= nx.bw; b_height <= nx.bh; b_angle <= nx.ba;
					next_start = 1'b1;
				end
			end
			start <= next_start;
		end
	end

	// monitor: every done strobe is checked against the oldest expectation
	always @(posedge clk) begin
		box_result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result strobe with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (overlap !== e.ovl) begin
					$error("overlap exp %0d got %0d", e.ovl, overlap); errors++;
				end
				if (bbox_min_x !== e.mnx) begin
					$error("bbox_min_x exp %0d got %0d", e.mnx, bbox_min_x); errors++;
				end
				if (bbox_min_y !== e.mny) begin
					$error("bbox_min_y exp %0d got %0d", e.mny, bbox_min_y); errors++;
				end
				if (bbox_span_x !== e.spx) begin
					$error("bbox_span_x exp %0d got %0d", e.spx, bbox_span_x); errors++;
				end
				if (bbox_span_y !== e.spy) begin
					$error("bbox_span_y exp %0d got %0d", e.spy, bbox_span_y); errors++;
				end
			end
		end
	end

	function automatic box_pair_t make_pair(int acx, acy, aw, ah, aa, bcx, bcy, bw, bh, ba);
		box_pair_t p;
		p.acx = CB'(acx); p.acy = CB'(acy); p.aw = (CB-1)'(aw); p.ah = (CB-1)'(ah);
		p.aa = AB'(aa);
		p.bcx = CB'(bcx); p.bcy = CB'(bcy); p.bw = (CB-1)'(bw); p.bh = (CB-1)'(bh);
		p.ba = AB'(ba);
		p.idle_pct = 0;
		p.drain = 0;
		return p;
	endfunction

	function automatic box_pair_t random_pair(int pct);
		box_pair_t p;
		if ($urandom_range(3) == 0) begin
			// full range, every bit toggles
			p.acx = CB'($urandom); p.acy = CB'($urandom);
			p.aw = (CB-1)'($urandom); p.ah = (CB-1)'($urandom);
			p.aa = AB'($urandom); p.bcx = CB'($urandom); p.bcy = CB'($urandom);
			p.bw = (CB-1)'($urandom); p.bh = (CB-1)'($urandom);
			p.ba = AB'($urandom);
		end else begin
			// nearby boxes so overlap goes both ways
			p.acx = CB'(int'($urandom_range(16383)) - 8192);
			p.acy = CB'(int'($urandom_range(16383)) - 8192);
			p.aw = (CB-1)'($urandom_range(12000)); p.ah = (CB-1)'($urandom_range(12000));
			p.aa = AB'($urandom);
			p.bcx = CB'(int'(p.acx) + int'($urandom_range(16383)) - 8192);
			p.bcy = CB'(int'(p.acy) + int'($urandom_range(16383)) - 8192);
			p.bw = (CB-1)'($urandom_range(12000)); p.bh = (CB-1)'($urandom_range(12000));
			p.ba = AB'($urandom);
		end
		p.idle_pct = pct;
		p.drain = ($urandom_range(199) == 0);
		return p;
	endfunction

	initial begin
		int pcts[4];
		box_pair_t p;
		pcts = '{0, 47, 0, 12};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// touching edges along x, then along y, then a sliver of overlap
		pending_pairs.push_back(make_pair(0, 0, 512, 512, 0, 512, 0, 512, 512, 0));
		pending_pairs.push_back(make_pair(0, 0, 512, 512, 0, 0, 512, 512, 512, 0));
		pending_pairs.push_back(make_pair(0, 0, 512, 512, 0, 511, 0, 512, 512, 0));
		// boxes at the quadrant boundary angles; only the first pair is identical
		pending_pairs.push_back(make_pair(100, -100, 800, 300, 16384, 100, -100, 800, 300, 16384));
		pending_pairs.push_back(make_pair(100, -100, 800, 300, 32768, 100, -100, 800, 300, 49152));
		pending_pairs.push_back(make_pair(0, 0, 800, 300, 65535, 50, 50, 300, 800, 8192));
		// zero size boxes
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 1000, 1234, 0, 0, 1000, 0, 40000));
		// coordinate and size extremes, bounds saturate
		pending_pairs.push_back(make_pair(8388607, 8388607, 8388607, 8388607, 8192,
			-8388608, -8388608, 8388607, 8388607, 24576));
		pending_pairs.push_back(make_pair(-8388608, -8388608, 8388607, 8388607, 0,
			8388607, 8388607, 8388607, 8388607, 65535));
		pending_pairs.push_back(make_pair(-8388608, 8388607, 8388607, 0, 57344,
			-8388608, 8388607, 0, 8388607, 0));
		pending_pairs.push_back(make_pair(5000, 5000, 100, 100, 0, -5000, -5000, 100, 100, 0));
		p = make_pair(0, 0, 4096, 2048, 10000, 1000, 1000, 2048, 4096, 50000);
		p.drain = 1;
		pending_pairs.push_back(p);

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 440; i++) begin
				p = random_pair(pcts[ph]);
				if (i == 0) p.drain = 1;
				pending_pairs.push_back(p);
			end
		end

		wait (pending_pairs.size() == 0);
		@(posedge clk);
		while (start || expected_results.size() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
